### sv/spag_pkg.sv
// Shared constants and bitboard helper functions for the sliding-piece attack generator.
`default_nettype none

package spag_pkg;

    // Board geometry and field widths.
    localparam int BOARD_W      = 64;
    localparam int SQ_W         = 6;
    localparam int SIDE         = 8;
    localparam int NUM_DIRS     = 4;
    localparam int MAX_STEPS    = 7;
    localparam int SUBSET_W     = 12;
    localparam int CNT_W        = 4;
    localparam int MAX_MASK_BITS = 12;

    typedef logic [BOARD_W-1:0] t_board;
    typedef logic [SQ_W-1:0]    t_square;
    typedef logic [CNT_W-1:0]   t_count;

    // Ray directions as rank and file steps.
    localparam int ROOK_DR [NUM_DIRS] = '{1, -1, 0, 0};
    localparam int ROOK_DF [NUM_DIRS] = '{0, 0, 1, -1};
    localparam int BISH_DR [NUM_DIRS] = '{1, 1, -1, -1};
    localparam int BISH_DF [NUM_DIRS] = '{1, -1, 1, -1};

    // Relevance mask: every ray square except the last square of each ray.
    // Each target square is decided on its own from its rank and file.
    function automatic t_board f_relevance(input t_square sq, input logic bishop);
        int     r;
        int     f;
        int     tr;
        int     tf;
        int     dr;
        int     df;
        logic   interior_r;
        logic   interior_f;
        t_board m;
        r = int'(sq[5:3]);
        f = int'(sq[2:0]);
        m = '0;
        for (int t = 0; t < BOARD_W; t++) begin
            tr = t >> 3;
            tf = t & (SIDE - 1);
            dr = tr - r;
            df = tf - f;
            interior_r = (tr >= 1) && (tr <= SIDE - 2);
            interior_f = (tf >= 1) && (tf <= SIDE - 2);
            if (t != (r * SIDE + f)) begin
                if (bishop) begin
                    m[t] = ((dr == df) || (dr == -df)) && interior_r && interior_f;
                end else begin
                    m[t] = ((tr == r) && interior_f) || ((tf == f) && interior_r);
                end
            end
        end
        return m;
    endfunction

    // Attack set: each ray runs outward and stops after the first blocked square.
    function automatic t_board f_attacks(input t_square sq, input logic bishop,
                                         input t_board blk);
        int     tr;
        int     tf;
        int     dr;
        int     df;
        logic   open;
        t_board a;
        a = '0;
        for (int d = 0; d < NUM_DIRS; d++) begin
            dr   = bishop ? BISH_DR[d] : ROOK_DR[d];
            df   = bishop ? BISH_DF[d] : ROOK_DF[d];
            tr   = int'(sq[5:3]);
            tf   = int'(sq[2:0]);
            open = 1'b1;
            for (int k = 0; k < MAX_STEPS; k++) begin
                tr = tr + dr;
                tf = tf + df;
                if (open && (tr >= 0) && (tr < SIDE) && (tf >= 0) && (tf < SIDE)) begin
                    a[SQ_W'(tr * SIDE + tf)] = 1'b1;
                    if (blk[SQ_W'(tr * SIDE + tf)]) begin
                        open = 1'b0;
                    end
                end else begin
                    open = 1'b0;
                end
            end
        end
        return a;
    endfunction

endpackage

`default_nettype wire

### sv/spag_subset.sv
// Scatters the subset index onto the set bits of the relevance mask and counts the mask.
`default_nettype none

module spag_subset (
    input  wire spag_pkg::t_board                  i_mask,
    input  wire logic [spag_pkg::SUBSET_W-1:0]     i_index,
    output spag_pkg::t_board                       o_subset,
    output spag_pkg::t_count                       o_count
);

    localparam int ROWS = spag_pkg::BOARD_W / spag_pkg::SIDE;

    spag_pkg::t_count row_cnt [ROWS];
    spag_pkg::t_count row_base [ROWS];
    logic [2**spag_pkg::CNT_W-1:0] idx_ext;

    assign idx_ext = {{(2**spag_pkg::CNT_W - spag_pkg::SUBSET_W){1'b0}}, i_index};

    // Mask bits in each rank row.
    always_comb begin
        for (int j = 0; j < ROWS; j++) begin
            row_cnt[j] = spag_pkg::CNT_W'($countones(i_mask[j*spag_pkg::SIDE +: spag_pkg::SIDE]));
        end
    end

    // Running count of mask bits below each row, and the total.
    always_comb begin
        row_base[0] = '0;
        for (int j = 1; j < ROWS; j++) begin
            row_base[j] = row_base[j-1] + row_cnt[j-1];
        end
        o_count = row_base[ROWS-1] + row_cnt[ROWS-1];
    end

    // Within a row, each mask bit takes the index bit at its rank among mask bits.
    always_comb begin
        spag_pkg::t_count run;
        o_subset = '0;
        for (int j = 0; j < ROWS; j++) begin
            run = row_base[j];
            for (int k = 0; k < spag_pkg::SIDE; k++) begin
                if (i_mask[j*spag_pkg::SIDE + k]) begin
                    o_subset[j*spag_pkg::SIDE + k] = idx_ext[run];
                    run = run + spag_pkg::CNT_W'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

### sv/sliding_piece_attack_generator_core.sv
// Top level of the rook and bishop sliding attack generator with its two-register pipeline.
//
//  Channel | Direction | Handshake          | Beat contents
//  --------+-----------+--------------------+----------------------------------------------
//  query   | in        | i_valid / o_stall  | square, is_bishop, use_index, occupancy,
//          |           |                    | subset_index
//  result  | out       | o_valid / i_stall  | attack_set, relevance_mask, mask_bit_count,
//          |           |                    | blockers_used
//
// A beat is captured in the input register and then in the result register; one beat is
// accepted every cycle while o_stall is low.
// The result register frees when the far side takes a beat; input stall is raised only
// when both registers are full and the output is stalled.
// Reset is synchronous and clears both valid flags; payload registers are not reset.
`default_nettype none

module sliding_piece_attack_generator_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [spag_pkg::SQ_W-1:0]         i_square,
    input  wire logic                              i_is_bishop,
    input  wire logic                              i_use_index,
    input  wire logic [spag_pkg::BOARD_W-1:0]      i_occupancy,
    input  wire logic [spag_pkg::SUBSET_W-1:0]     i_subset_index,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [spag_pkg::BOARD_W-1:0]           o_attack_set,
    output logic [spag_pkg::BOARD_W-1:0]           o_relevance_mask,
    output logic [spag_pkg::CNT_W-1:0]             o_mask_bit_count,
    output logic [spag_pkg::BOARD_W-1:0]           o_blockers_used
);

    // Input register.
    logic                          r_s1_vld;
    spag_pkg::t_square             r_s1_square;
    logic                          r_s1_bishop;
    logic                          r_s1_use_index;
    spag_pkg::t_board              r_s1_occ;
    logic [spag_pkg::SUBSET_W-1:0] r_s1_index;

    // Result register.
    logic                          r_out_vld;
    spag_pkg::t_board              r_out_attack;
    spag_pkg::t_board              r_out_mask;
    spag_pkg::t_count              r_out_count;
    spag_pkg::t_board              r_out_block;

    // Datapath between the registers.
    spag_pkg::t_board              n_mask;
    spag_pkg::t_board              n_subset;
    spag_pkg::t_count              n_count;
    spag_pkg::t_board              n_block;
    spag_pkg::t_board              n_attack;

    logic                          s1_ready;
    logic                          s2_ready;

    // Flow control: each register loads when it is empty or its contents move on.
    assign s2_ready = !r_out_vld || !i_stall;
    assign s1_ready = !r_s1_vld || s2_ready;
    assign o_stall  = !s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_ready) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && s1_ready) begin
            r_s1_square    <= i_square;
            r_s1_bishop    <= i_is_bishop;
            r_s1_use_index <= i_use_index;
            r_s1_occ       <= i_occupancy;
            r_s1_index     <= i_subset_index;
        end
    end

    // Relevance mask, blocker selection and ray walk.
    assign n_mask = spag_pkg::f_relevance(r_s1_square, r_s1_bishop);

    spag_subset u_subset (
        .i_mask   (n_mask),
        .i_index  (r_s1_index),
        .o_subset (n_subset),
        .o_count  (n_count)
    );

    assign n_block  = r_s1_use_index ? n_subset : r_s1_occ;
    assign n_attack = spag_pkg::f_attacks(r_s1_square, r_s1_bishop, n_block);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s2_ready) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld && s2_ready) begin
            r_out_attack <= n_attack;
            r_out_mask   <= n_mask;
            r_out_count  <= n_count;
            r_out_block  <= n_block;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_attack_set     = r_out_attack;
    assign o_relevance_mask = r_out_mask;
    assign o_mask_bit_count = r_out_count;
    assign o_blockers_used  = r_out_block;

    // The reported count matches the mask it goes with.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (32'(r_out_count) == $countones(r_out_mask)))
        else $error("mask bit count disagrees with relevance mask");

    // A relevance mask never holds more than twelve squares.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (32'(r_out_count) <= spag_pkg::MAX_MASK_BITS))
        else $error("mask bit count out of range");

    // Every square has at least one attacked neighbor.
    a_attack_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_attack != '0))
        else $error("empty attack set");

    // A beat in the input register with room ahead reaches the result register.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && s2_ready) |=> r_out_vld)
        else $error("beat lost between input and result registers");

    // An accepted beat always lands in the input register.
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_s1_vld)
        else $error("accepted beat not captured");

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the rook and bishop sliding attack generator core.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT    = 11;
    localparam int STUCK_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;

    typedef struct {
        spag_pkg::t_square                 square;
        logic                              is_bishop;
        logic                              use_index;
        spag_pkg::t_board                  occupancy;
        logic [spag_pkg::SUBSET_W-1:0]     subset_index;
    } t_attack_query;

    typedef struct {
        spag_pkg::t_board attack_set;
        spag_pkg::t_board relevance_mask;
        spag_pkg::t_count mask_bit_count;
        spag_pkg::t_board blockers_used;
    } t_attack_result;

    // Clock, reset and block ports; every input starts at a known value.
    logic                              i_clk          = 1'b0;
    logic                              i_rst_n        = 1'b0;
    logic                              i_valid        = 1'b0;
    logic                              i_stall        = 1'b0;
    spag_pkg::t_square                 i_square       = '0;
    logic                              i_is_bishop    = 1'b0;
    logic                              i_use_index    = 1'b0;
    spag_pkg::t_board                  i_occupancy    = '0;
    logic [spag_pkg::SUBSET_W-1:0]     i_subset_index = '0;
    logic                              o_stall;
    logic                              o_valid;
    spag_pkg::t_board                  o_attack_set;
    spag_pkg::t_board                  o_relevance_mask;
    spag_pkg::t_count                  o_mask_bit_count;
    spag_pkg::t_board                  o_blockers_used;

    t_attack_query  pending_queries[$];
    t_attack_result expected_attacks[$];
    t_attack_query  driven_query;
    t_attack_result oldest_attack;
    int             error_count  = 0;
    int             stuck_cycles = 0;
    logic           steady       = 1'b0;

    sliding_piece_attack_generator_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_square         (i_square),
        .i_is_bishop      (i_is_bishop),
        .i_use_index      (i_use_index),
        .i_occupancy      (i_occupancy),
        .i_subset_index   (i_subset_index),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_attack_set     (o_attack_set),
        .o_relevance_mask (o_relevance_mask),
        .o_mask_bit_count (o_mask_bit_count),
        .o_blockers_used  (o_blockers_used)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic on_board(int r, int f);
        return (r >= 0) && (r < 8) && (f >= 0) && (f < 8);
    endfunction

    // Walk the four rays of the piece. With trim set, the last square of every ray is
    // left out and blockers are ignored, which gives the relevance mask; otherwise a ray
    // stops right after its first blocked square, which gives the attack set.
    function automatic spag_pkg::t_board walk_rays(spag_pkg::t_square sq, logic bishop,
                                                   spag_pkg::t_board blk, logic trim);
        spag_pkg::t_board out;
        int     dr;
        int     df;
        int     r;
        int     f;
        logic   go;
        out = '0;
        for (int d = 0; d < 4; d++) begin
            if (bishop) begin
                dr = (d < 2) ? 1 : -1;
                df = (d % 2 == 0) ? 1 : -1;
            end else begin
                dr = (d == 0) ? 1 : ((d == 1) ? -1 : 0);
                df = (d == 2) ? 1 : ((d == 3) ? -1 : 0);
            end
            r  = int'(sq[5:3]) + dr;
            f  = int'(sq[2:0]) + df;
            go = on_board(r, f);
            while (go) begin
                if (trim && !on_board(r + dr, f + df)) begin
                    go = 1'b0;
                end else begin
                    out[r * 8 + f] = 1'b1;
                    if (!trim && blk[r * 8 + f]) begin
                        go = 1'b0;
                    end
                    r  = r + dr;
                    f  = f + df;
                    go = go && on_board(r, f);
                end
            end
        end
        return out;
    endfunction

    // Expected result of one query: mask, scattered subset, chosen blockers and rays.
    function automatic t_attack_result predict_attack(t_attack_query q);
        t_attack_result   res;
        spag_pkg::t_board subset;
        int               n;
        res.relevance_mask = walk_rays(q.square, q.is_bishop, '0, 1'b1);
        subset = '0;
        n      = 0;
        for (int b = 0; b < 64; b++) begin
            if (res.relevance_mask[b]) begin
                if (n < spag_pkg::SUBSET_W && q.subset_index[n]) begin
                    subset[b] = 1'b1;
                end
                n++;
            end
        end
        res.mask_bit_count = spag_pkg::t_count'(n);
        res.blockers_used  = q.use_index ? subset : q.occupancy;
        res.attack_set     = walk_rays(q.square, q.is_bishop, res.blockers_used, 1'b0);
        return res;
    endfunction

    // Query driver: a beat moves on once accepted, or when the channel is empty.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_attacks.push_back(predict_attack(driven_query));
            end
            if (!i_valid || !o_stall) begin
                if (pending_queries.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    driven_query    = pending_queries.pop_front();
                    i_square       <= driven_query.square;
                    i_is_bishop    <= driven_query.is_bishop;
                    i_use_index    <= driven_query.use_index;
                    i_occupancy    <= driven_query.occupancy;
                    i_subset_index <= driven_query.subset_index;
                    i_valid        <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each accepted beat with the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_attacks.size() == 0) begin
                    $error("result beat with nothing expected: attack_set %h", o_attack_set);
                    error_count++;
                end else begin
                    oldest_attack = expected_attacks.pop_front();
                    if (o_attack_set !== oldest_attack.attack_set) begin
                        $error("attack_set: expected %h, actual %h",
                               oldest_attack.attack_set, o_attack_set);
                        error_count++;
                    end
                    if (o_relevance_mask !== oldest_attack.relevance_mask) begin
                        $error("relevance_mask: expected %h, actual %h",
                               oldest_attack.relevance_mask, o_relevance_mask);
                        error_count++;
                    end
                    if (o_mask_bit_count !== oldest_attack.mask_bit_count) begin
                        $error("mask_bit_count: expected %0d, actual %0d",
                               oldest_attack.mask_bit_count, o_mask_bit_count);
                        error_count++;
                    end
                    if (o_blockers_used !== oldest_attack.blockers_used) begin
                        $error("blockers_used: expected %h, actual %h",
                               oldest_attack.blockers_used, o_blockers_used);
                        error_count++;
                    end
                end
            end
            i_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog: too many cycles in a row without any accepted beat ends the run.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic push_query(spag_pkg::t_square sq, logic bishop, logic use_idx,
                              spag_pkg::t_board occ, logic [spag_pkg::SUBSET_W-1:0] idx);
        t_attack_query q;
        q.square       = sq;
        q.is_bishop    = bishop;
        q.use_index    = use_idx;
        q.occupancy    = occ;
        q.subset_index = idx;
        pending_queries.push_back(q);
    endtask

    // Random queries: sparse, dense and plain occupancies, about half in index mode.
    task automatic queue_random(int count);
        spag_pkg::t_board occ;
        for (int k = 0; k < count; k++) begin
            occ = {$urandom, $urandom};
            case ($urandom_range(3))
                0: begin
                    occ = occ & {$urandom, $urandom} & {$urandom, $urandom};
                end
                1: begin
                    occ = occ | {$urandom, $urandom};
                end
                default: begin
                end
            endcase
            push_query(spag_pkg::t_square'($urandom_range(63)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), occ,
                       spag_pkg::SUBSET_W'($urandom_range(4095)));
        end
    endtask

    // Hold off until every queued query is sent and every expected result has come.
    task automatic wait_drained();
        while (pending_queries.size() != 0 || i_valid || expected_attacks.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: corners and center, empty and full boards, both blocker sources.
        push_query(6'd0,  1'b0, 1'b0, '0, '0);
        push_query(6'd63, 1'b0, 1'b0, '1, '0);
        push_query(6'd7,  1'b1, 1'b0, '0, '0);
        push_query(6'd56, 1'b1, 1'b0, '1, '1);
        push_query(6'd27, 1'b0, 1'b0, '0, '0);
        push_query(6'd27, 1'b1, 1'b0, '1, '0);
        push_query(6'd0,  1'b0, 1'b1, '0, 12'hfff);
        push_query(6'd0,  1'b0, 1'b1, '1, 12'h000);
        push_query(6'd63, 1'b0, 1'b1, '0, 12'h800);
        // Index bits above the mask size must not select anything.
        push_query(6'd63, 1'b1, 1'b1, '1, 12'hfff);
        push_query(6'd0,  1'b1, 1'b1, '0, 12'hfc0);
        push_query(6'd36, 1'b1, 1'b1, '1, 12'h555);
        push_query(6'd9,  1'b0, 1'b1, {$urandom, $urandom}, 12'haaa);
        // An occupied origin square alone blocks nothing.
        push_query(6'd35, 1'b0, 1'b0, 64'd1 << 35, '0);
        push_query(6'd18, 1'b1, 1'b0, 64'd1 << 18, '0);
        // Blockers that sit off every ray change nothing.
        push_query(6'd35, 1'b0, 1'b0, ~walk_rays(6'd35, 1'b0, '0, 1'b0), '0);
        push_query(6'd18, 1'b1, 1'b0, ~walk_rays(6'd18, 1'b1, '0, 1'b0), '0);
        push_query(6'd7,  1'b0, 1'b0, 64'h8000_0000_0000_0080, '0);
        push_query(6'd56, 1'b0, 1'b1, '0, 12'hfff);
        push_query(6'd28, 1'b1, 1'b1, '0, 12'h1ff);
        wait_drained();

        // Random part, with a full drain, then a stretch with no idling on either side, then idling again.
        queue_random(900);
        wait_drained();
        steady = 1'b1;
        queue_random(400);
        wait_drained();
        steady = 1'b0;
        queue_random(550);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
sv/spag_pkg.sv
sv/spag_subset.sv
sv/sliding_piece_attack_generator_core.sv
dv/tb.sv
